@@ rtl/prq_pkg.sv @@
// ============================================================================
// prq_pkg
// Shared types and constants of the packet ring queue: request and status
// codes, field widths and the record carried by every result transfer.
// ============================================================================
package prq_pkg;

    // Default geometry of the queue
    localparam int DEPTH_DEF       = 8;
    localparam int FRAME_BYTES_DEF = 64;

    // Fixed widths of the stream fields
    localparam int REQ_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_LEN_W = 7;
    localparam int COUNT_W   = 4;
    localparam int DROPS_W   = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - BYTE_W - OUT_LEN_W - 1 - COUNT_W - DROPS_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_BYTE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]    byte_val;
        logic                 last;
        logic [STATUS_W-1:0]  status;
        logic [OUT_LEN_W-1:0] length;
        logic                 empty;
        logic [COUNT_W-1:0]   count;
        logic [DROPS_W-1:0]   drops;
    } prq_result_t;

    // Occupancy report of the output buffer towards the sequencer
    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } prq_buf_stat_t;

endpackage

@@ rtl/prq_ram.sv @@
// ============================================================================
// prq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/prq_out_buf.sv @@
// ============================================================================
// prq_out_buf
// Two-entry output buffer: an output register backed by a skid register, so
// that results keep flowing while the receiver stalls.
// ============================================================================
module prq_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  prq_pkg::prq_result_t push_res,
    output prq_pkg::prq_result_t out_res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output prq_pkg::prq_buf_stat_t stat
);

    import prq_pkg::*;

    logic        head_valid_reg;
    logic        skid_valid_reg;
    prq_result_t head_reg;
    prq_result_t skid_reg;
    logic        pop;

    assign pop        = head_valid_reg & out_ready;
    assign out_valid  = head_valid_reg;
    assign out_res    = head_reg;
    assign stat.pop   = pop;
    assign stat.level = {1'b0, head_valid_reg} + {1'b0, skid_valid_reg};

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            case ({pop, push})
                2'b01:
                begin
                    if (head_valid_reg)
                    begin
                        skid_valid_reg <= 1'b1;
                    end
                    head_valid_reg <= 1'b1;
                end
                2'b10:
                begin
                    if (skid_valid_reg)
                    begin
                        skid_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        head_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case ({pop, push})
            2'b01:
            begin
                if (head_valid_reg)
                begin
                    skid_reg <= push_res;
                end
                else
                begin
                    head_reg <= push_res;
                end
            end
            2'b10:
            begin
                if (skid_valid_reg)
                begin
                    head_reg <= skid_reg;
                end
            end
            2'b11:
            begin
                if (skid_valid_reg)
                begin
                    head_reg <= skid_reg;
                    skid_reg <= push_res;
                end
                else
                begin
                    head_reg <= push_res;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/packet_ring_queue_core.sv @@
// ============================================================================
// packet_ring_queue_core
// Ring of frame slots with a drop counter, held in two synchronous RAMs.
// ============================================================================
// Usage: requests arrive on the s_axis channel (tuser selects push, pop or
// clear; tdata is the byte; tlast marks the final byte of a pushed frame).
// Results leave on the m_axis channel, tuser carrying the status and tlast
// the final result of a request.
// A frame end gives its status result through the result stage register and
// then the output buffer. A pop reads the slot length from the length RAM,
// then streams one byte per cycle from the byte RAM while the output buffer
// has room for a result. Empty, clear and status results likewise pass
// through the result stage register and then the output buffer.
// Only one request is in work at a time; s_axis_tready is high while the
// sequencer is idle and the output buffer has room for a result.
// A stalled receiver fills the two-entry output buffer, after which byte
// reads and new requests wait; nothing is lost.
// Reset empties the queue, zeroes the drop count, abandons any partial frame
// and flushes the output buffer. RAM contents are not cleared.
// ============================================================================
module packet_ring_queue_core #(
    parameter int DEPTH       = prq_pkg::DEPTH_DEF,
    parameter int FRAME_BYTES = prq_pkg::FRAME_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [prq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // in_byte[7:0]
    input  logic [prq_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type[1:0]
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_byte[7:0], out_length[14:8], is_empty[15], entry_count[19:16],
    // drops_seen[51:20], zero fill[55:52]
    output logic [prq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [prq_pkg::STATUS_W-1:0]    m_axis_tuser,  // status[2:0]
    output logic                            m_axis_tlast
);

    import prq_pkg::*;

    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int LEN_W   = $clog2(FRAME_BYTES + 1);
    localparam int HELD_W  = $clog2(DEPTH + 1);
    localparam int BYTES_DEPTH = DEPTH * (2 ** POS_W);
    localparam int BADDR_W = $clog2(BYTES_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LEN    = 3'b010,
        S_STREAM = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]   read_slot_reg, read_slot_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [DROPS_W-1:0]  drops_reg, drops_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic                too_long_reg, too_long_next;
    logic                fas_reg, fas_next;
    logic [SLOT_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    beat_reg, beat_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_mem_reg, s1_mem_next;
    prq_result_t         s1_res_reg, s1_res_next;

    logic                accept;
    logic                credit;
    logic                fas_now;
    logic                room;
    logic                too_long_after;
    logic [LEN_W-1:0]    pos_after;
    logic [LEN_W-1:0]    len_fix;
    logic [LEN_W-1:0]    beat_inc;
    logic                beat_last;
    logic [31:0]         held_wide;
    logic [STATUS_W-1:0] res_status;
    logic                res_last;
    logic [LEN_W-1:0]    res_len;

    logic                bwr_en;
    logic                brd_en;
    logic [BADDR_W-1:0]  brd_addr;
    logic [BYTE_W-1:0]   brd_data;
    logic                lwr_en;
    logic                lrd_en;
    logic [LEN_W-1:0]    lrd_data;

    prq_result_t         buf_in;
    prq_result_t         buf_out;
    prq_buf_stat_t       buf_stat;

    // A result may be issued when buffer plus the stage in flight leave room
    assign credit = ({1'b0, buf_stat.level} + {2'b0, s1_valid_reg})
                    < (3'd2 + {2'b0, buf_stat.pop});
    assign s_axis_tready = (state_reg == S_IDLE) && credit;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Push bookkeeping derived from the frame state
    assign fas_now = (pos_reg == '0 && !too_long_reg) ?
                     (held_reg >= HELD_W'(DEPTH)) : fas_reg;
    assign room           = pos_reg < LEN_W'(FRAME_BYTES);
    assign pos_after      = room ? pos_reg + 1'b1 : pos_reg;
    assign too_long_after = too_long_reg | ~room;

    // Stored length, clamped into the legal range
    assign len_fix = (lrd_data > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) :
                     ((lrd_data == '0) ? LEN_W'(1) : lrd_data);

    assign beat_inc  = LEN_W'(beat_reg) + 1'b1;
    assign beat_last = (beat_inc == len_reg);

    assign bwr_en   = accept && (s_axis_tuser == REQ_PUSH) && room && !fas_now;
    assign lwr_en   = accept && (s_axis_tuser == REQ_PUSH) && s_axis_tlast
                      && !too_long_after && !fas_now;
    assign lrd_en   = accept && (s_axis_tuser == REQ_POP) && (held_reg != '0);
    assign brd_en   = (state_reg == S_STREAM) && credit;
    assign brd_addr = BADDR_W'({rd_slot_reg, beat_reg});

    // Sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        held_next       = held_reg;
        drops_next      = drops_reg;
        pos_next        = pos_reg;
        too_long_next   = too_long_reg;
        fas_next        = fas_reg;
        rd_slot_next    = rd_slot_reg;
        len_next        = len_reg;
        beat_next       = beat_reg;
        s1_valid_next   = 1'b0;
        s1_mem_next     = 1'b0;
        res_status      = ST_BYTE;
        res_last        = 1'b1;
        res_len         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tuser)
                        REQ_PUSH:
                        begin
                            if (s_axis_tlast)
                            begin
                                s1_valid_next = 1'b1;
                                pos_next      = '0;
                                too_long_next = 1'b0;
                                fas_next      = 1'b0;
                                if (too_long_after)
                                begin
                                    res_status = ST_REJECTED;
                                end
                                else if (fas_now)
                                begin
                                    res_status = ST_DROPPED;
                                    drops_next = drops_reg + 1'b1;
                                end
                                else
                                begin
                                    res_status      = ST_ACCEPTED;
                                    held_next       = held_reg + 1'b1;
                                    write_slot_next = (write_slot_reg == SLOT_W'(DEPTH - 1)) ?
                                                      '0 : write_slot_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                pos_next      = pos_after;
                                too_long_next = too_long_after;
                                fas_next      = fas_now;
                            end
                        end
                        REQ_POP:
                        begin
                            if (held_reg == '0)
                            begin
                                s1_valid_next = 1'b1;
                                res_status    = ST_EMPTY;
                            end
                            else
                            begin
                                rd_slot_next   = read_slot_reg;
                                read_slot_next = (read_slot_reg == SLOT_W'(DEPTH - 1)) ?
                                                 '0 : read_slot_reg + 1'b1;
                                held_next      = held_reg - 1'b1;
                                state_next     = S_LEN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            s1_valid_next   = 1'b1;
                            res_status      = ST_CLEARED;
                            write_slot_next = '0;
                            read_slot_next  = '0;
                            held_next       = '0;
                            drops_next      = '0;
                            pos_next        = '0;
                            too_long_next   = 1'b0;
                            fas_next        = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                len_next   = len_fix;
                beat_next  = '0;
                state_next = S_STREAM;
            end
            S_STREAM:
            begin
                if (credit)
                begin
                    s1_valid_next = 1'b1;
                    s1_mem_next   = 1'b1;
                    res_status    = ST_BYTE;
                    res_last      = beat_last;
                    res_len       = len_reg;
                    beat_next     = beat_reg + 1'b1;
                    if (beat_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        held_wide            = 32'(held_next);
        s1_res_next.byte_val = '0;
        s1_res_next.last     = res_last;
        s1_res_next.status   = res_status;
        s1_res_next.length   = OUT_LEN_W'(res_len);
        s1_res_next.empty    = (held_next == '0);
        s1_res_next.count    = held_wide[COUNT_W-1:0];
        s1_res_next.drops    = drops_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            held_reg       <= '0;
            drops_reg      <= '0;
            pos_reg        <= '0;
            too_long_reg   <= 1'b0;
            fas_reg        <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            held_reg       <= held_next;
            drops_reg      <= drops_next;
            pos_reg        <= pos_next;
            too_long_reg   <= too_long_next;
            fas_reg        <= fas_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // Payload registers of the sequencer and the result stage
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        len_reg     <= len_next;
        beat_reg    <= beat_next;
        s1_mem_reg  <= s1_mem_next;
        s1_res_reg  <= s1_res_next;
    end

    // Frame byte store
    prq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BYTES_DEPTH)
    ) u_bytes (
        .clk     (clk),
        .wr_en   (bwr_en),
        .wr_addr (BADDR_W'({write_slot_reg, pos_reg[POS_W-1:0]})),
        .wr_data (s_axis_tdata),
        .rd_en   (brd_en),
        .rd_addr (brd_addr),
        .rd_data (brd_data)
    );

    // Frame length store
    prq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (DEPTH)
    ) u_lengths (
        .clk     (clk),
        .wr_en   (lwr_en),
        .wr_addr (write_slot_reg),
        .wr_data (pos_after),
        .rd_en   (lrd_en),
        .rd_addr (read_slot_reg),
        .rd_data (lrd_data)
    );

    // Merge the byte read back into the result
    always_comb
    begin
        buf_in = s1_res_reg;
        if (s1_mem_reg)
        begin
            buf_in.byte_val = brd_data;
        end
    end

    prq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_res  (buf_in),
        .out_res   (buf_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (buf_stat)
    );

    // Output packing
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, buf_out.drops, buf_out.count,
                           buf_out.empty, buf_out.length, buf_out.byte_val};
    assign m_axis_tuser = buf_out.status;
    assign m_axis_tlast = buf_out.last;

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench
// Self-checking bench for packet_ring_queue_core. A short table of directed
// requests covers the extremes, every request code and the corner cases of
// the frame queue (overlong frames, a full ring, pops during a partial push,
// clears and ignored selectors). Long random runs of frames, a few overlong,
// mixed with pops, clears and noise follow. Every accepted result transfer
// is compared field by field against an in-bench model of the queue, while
// both stream sides idle and stall at random.
// ============================================================================
module testbench;

    import prq_pkg::*;

    // Geometry of the queue under test
    localparam int QUEUE_SLOTS = DEPTH_DEF;
    localparam int FRAME_MAX   = FRAME_BYTES_DEF;

    // The fourth selector value is ignored by the block
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

    // Run shape
    localparam int TOTAL_ITEMS  = 460;
    localparam int HOLD_AT      = 280;
    localparam int DRAIN_AT     = 380;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DIR_ROWS     = 25;

    // One row of the directed table
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] din;
        logic              lst;
        logic [7:0]        reps;
        logic              typed;
        prq_result_t       want;
    } stim_row_t;

    localparam prq_result_t NO_CHECK = '0;

    // Stimulus and handshake signals
    logic                  clk    = 1'b0;
    logic                  rst_n  = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [REQ_W-1:0]      s_user = '0;
    logic                  s_last = 1'b0;
    logic                  m_rdy  = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    // Model of the queue contents
    logic [BYTE_W-1:0]    frame_store [QUEUE_SLOTS*FRAME_MAX];
    logic [OUT_LEN_W-1:0] frame_len   [QUEUE_SLOTS];
    int unsigned          wr_slot        = 0;
    int unsigned          rd_slot        = 0;
    int unsigned          frames_stored  = 0;
    int unsigned          bytes_in_frame = 0;
    logic [DROPS_W-1:0]   drop_count     = '0;
    bit                   frame_overlong = 1'b0;
    bit                   frame_blocked  = 1'b0;

    // Results still owed by the block, oldest first
    prq_result_t owed_results [$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  items_sent     = 0;
    int  burst_left     = 0;
    bit  hold_req       = 1'b0;

    stim_row_t directed_rows [DIR_ROWS];

    packet_ring_queue_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_rdy),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Reset is held at the start of the run only
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog on the whole run
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("status: fail");
        $finish;
    end

    // Builds a result with the occupancy fields taken from the model state.
    function automatic prq_result_t queue_result(logic [BYTE_W-1:0] b, logic lst,
                                                 logic [STATUS_W-1:0] st,
                                                 int unsigned len);
        prq_result_t r;
        r.byte_val = b;
        r.last     = lst;
        r.status   = st;
        r.length   = OUT_LEN_W'(len);
        r.empty    = (frames_stored == 0);
        r.count    = COUNT_W'(frames_stored);
        r.drops    = drop_count;
        return r;
    endfunction

    // Frame-end or status word as typed into the directed table.
    function automatic prq_result_t status_word(logic [STATUS_W-1:0] st, int unsigned cnt,
                                                int unsigned drops);
        prq_result_t r;
        r        = '0;
        r.last   = 1'b1;
        r.status = st;
        r.empty  = (cnt == 0);
        r.count  = COUNT_W'(cnt);
        r.drops  = DROPS_W'(drops);
        return r;
    endfunction

    // Advances the queue model by one request and queues the results it owes.
    function automatic void predict_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] din,
                                            logic lst);
        int unsigned         slot;
        int unsigned         len;
        logic [STATUS_W-1:0] st;
        case (req)
            REQ_PUSH:
            begin
                // Fullness is sampled on the first byte of a frame
                if (bytes_in_frame == 0 && !frame_overlong)
                    frame_blocked = (frames_stored >= QUEUE_SLOTS);
                if (bytes_in_frame < FRAME_MAX)
                begin
                    if (!frame_blocked)
                        frame_store[wr_slot*FRAME_MAX + bytes_in_frame] = din;
                    bytes_in_frame++;
                end
                else
                    frame_overlong = 1'b1;
                if (lst)
                begin
                    // An overlong frame wins over a full ring
                    if (frame_overlong)
                        st = ST_REJECTED;
                    else if (frame_blocked)
                    begin
                        drop_count++;
                        st = ST_DROPPED;
                    end
                    else
                    begin
                        frame_len[wr_slot] = OUT_LEN_W'(bytes_in_frame);
                        wr_slot            = (wr_slot + 1) % QUEUE_SLOTS;
                        frames_stored++;
                        st = ST_ACCEPTED;
                    end
                    bytes_in_frame = 0;
                    frame_overlong = 1'b0;
                    frame_blocked  = 1'b0;
                    owed_results.push_back(queue_result('0, 1'b1, st, 0));
                end
            end
            REQ_POP:
            begin
                if (frames_stored == 0)
                    owed_results.push_back(queue_result('0, 1'b1, ST_EMPTY, 0));
                else
                begin
                    slot = rd_slot;
                    len  = frame_len[slot];
                    if (len > FRAME_MAX)
                        len = FRAME_MAX;
                    if (len == 0)
                        len = 1;
                    rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
                    frames_stored--;
                    for (int i = 0; i < len; i++)
                        owed_results.push_back(queue_result(frame_store[slot*FRAME_MAX + i],
                                                            (i + 1 == len), ST_BYTE, len));
                end
            end
            REQ_CLEAR:
            begin
                wr_slot        = 0;
                rd_slot        = 0;
                frames_stored  = 0;
                drop_count     = '0;
                bytes_in_frame = 0;
                frame_overlong = 1'b0;
                frame_blocked  = 1'b0;
                owed_results.push_back(queue_result('0, 1'b1, ST_CLEARED, 0));
            end
            default:
                ;
        endcase
    endfunction

    // Offers one request and returns at the edge where its transfer completes.
    // Idle gaps between bursts are inserted before the request is raised.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] din,
                                input logic lst);
        if (burst_left == 0)
        begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(0, 12);
        end
        else
            burst_left--;
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= din;
        s_last  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        predict_request(req, din, lst);
        items_sent++;
    endtask

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // Compares the transfer on the result side with the oldest owed result.
    task automatic check_result();
        prq_result_t want;
        results_seen++;
        if (owed_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", 32'(m_axis_tuser), '0);
            return;
        end
        want = owed_results.pop_front();
        if (m_axis_tdata[7:0] !== want.byte_val)
            report_mismatch("out_byte", 32'(m_axis_tdata[7:0]), 32'(want.byte_val));
        if (m_axis_tlast !== want.last)
            report_mismatch("out_last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[14:8] !== want.length)
            report_mismatch("out_length", 32'(m_axis_tdata[14:8]), 32'(want.length));
        if (m_axis_tdata[15] !== want.empty)
            report_mismatch("is_empty", 32'(m_axis_tdata[15]), 32'(want.empty));
        if (m_axis_tdata[19:16] !== want.count)
            report_mismatch("entry_count", 32'(m_axis_tdata[19:16]), 32'(want.count));
        if (m_axis_tdata[51:20] !== want.drops)
            report_mismatch("drops_seen", m_axis_tdata[51:20], want.drops);
        if (m_axis_tdata[55:52] !== '0)
            report_mismatch("zero fill", 32'(m_axis_tdata[55:52]), '0);
    endtask

    // Result side: checks each transfer and stalls on a pattern of its own,
    // with one long hold-off when the stimulus asks for it.
    initial
    begin
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_rdy)
                check_result();
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_rdy <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                m_rdy <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_rdy <= 1'b0;
            end
            else
            begin
                run_left   = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 10);
                stall_left = $urandom_range(0, 5);
                m_rdy <= (stall_left == 0);
            end
        end
    end

    // Request side: directed table, then random frames, pops and clears.
    initial
    begin
        int pick;
        int flen;
        int noise;
        int size_pick;
        int pop_pct;
        int phase_left;
        bit hold_done;
        bit drained;
        pop_pct    = 20;
        phase_left = 0;
        hold_done  = 1'b0;
        drained    = 1'b0;

        // Overlong frames, a full ring and clears have their results typed in
        directed_rows = '{
            '{REQ_POP,     8'h00, 1'b0, 8'd1,  1'b1, status_word(ST_EMPTY, 0, 0)},
            '{REQ_IGNORED, 8'hFF, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_IGNORED, 8'h00, 1'b0, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'h00, 1'b1, 8'd1,  1'b1, status_word(ST_ACCEPTED, 1, 0)},
            '{REQ_PUSH,    8'hFF, 1'b1, 8'd2,  1'b1, status_word(ST_ACCEPTED, 2, 0)},
            '{REQ_POP,     8'hFF, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'h11, 1'b0, 8'd1,  1'b0, NO_CHECK},
            '{REQ_POP,     8'h00, 1'b0, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'h22, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_CLEAR,   8'h00, 1'b0, 8'd1,  1'b1, status_word(ST_CLEARED, 0, 0)},
            '{REQ_PUSH,    8'h40, 1'b1, 8'd64, 1'b1, status_word(ST_ACCEPTED, 1, 0)},
            '{REQ_PUSH,    8'h80, 1'b1, 8'd65, 1'b1, status_word(ST_REJECTED, 1, 0)},
            '{REQ_POP,     8'h00, 1'b0, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hC0, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hC4, 1'b1, 8'd3,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hC8, 1'b1, 8'd2,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hCC, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hD0, 1'b1, 8'd4,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hD4, 1'b1, 8'd1,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hD8, 1'b1, 8'd2,  1'b0, NO_CHECK},
            '{REQ_PUSH,    8'hDC, 1'b1, 8'd1,  1'b1, status_word(ST_ACCEPTED, 8, 0)},
            '{REQ_PUSH,    8'hE0, 1'b1, 8'd3,  1'b1, status_word(ST_DROPPED, 8, 1)},
            '{REQ_PUSH,    8'hF0, 1'b1, 8'd66, 1'b1, status_word(ST_REJECTED, 8, 1)},
            '{REQ_POP,     8'h00, 1'b0, 8'd1,  1'b0, NO_CHECK},
            '{REQ_CLEAR,   8'h00, 1'b1, 8'd1,  1'b1, status_word(ST_CLEARED, 0, 0)}
        };

        wait (rst_n);
        @(posedge clk);

        // Directed part: a push row expands into a frame of consecutive bytes
        foreach (directed_rows[r])
        begin
            for (int k = 0; k < int'(directed_rows[r].reps); k++)
                send_request(directed_rows[r].req, directed_rows[r].din + 8'(k),
                             (k == int'(directed_rows[r].reps) - 1) ? directed_rows[r].lst
                                                                     : 1'b0);
            if (directed_rows[r].typed)
                owed_results[owed_results.size() - 1] = directed_rows[r].want;
        end

        // Random part, in phases with different pop rates
        while (items_sent < TOTAL_ITEMS)
        begin
            // Long hold-off on the result side while requests keep coming
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            // One pause until every owed result has arrived
            if (!drained && items_sent >= DRAIN_AT)
            begin
                s_valid <= 1'b0;
                do @(posedge clk); while (owed_results.size() != 0);
                drained = 1'b1;
            end
            if (phase_left == 0)
            begin
                pop_pct    = $urandom_range(10, 45);
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_request(REQ_IGNORED, 8'($urandom), 1'($urandom));
            else if (pick < 5)
                send_request(REQ_CLEAR, 8'($urandom), 1'($urandom));
            else if (pick < 5 + pop_pct)
                send_request(REQ_POP, 8'($urandom), 1'($urandom));
            else
            begin
                // Mostly short frames, a few at or over the slot size
                size_pick = $urandom_range(0, 99);
                if (size_pick < 80)
                    flen = $urandom_range(1, 6);
                else if (size_pick < 94)
                    flen = $urandom_range(7, 20);
                else if (size_pick < 97)
                    flen = $urandom_range(21, FRAME_MAX - 1);
                else if (size_pick < 98)
                    flen = FRAME_MAX;
                else
                    flen = $urandom_range(FRAME_MAX + 1, FRAME_MAX + 3);
                for (int k = 0; k < flen; k++)
                begin
                    noise = $urandom_range(0, 99);
                    // A clear in mid-frame abandons the partial frame
                    if (k > 0 && noise == 5)
                    begin
                        send_request(REQ_CLEAR, 8'($urandom), 1'($urandom));
                        break;
                    end
                    if (noise < 4)
                        send_request(REQ_POP, 8'($urandom), 1'($urandom));
                    else if (noise == 4)
                        send_request(REQ_IGNORED, 8'($urandom), 1'($urandom));
                    send_request(REQ_PUSH, 8'($urandom), (k + 1 == flen));
                end
            end
        end

        // Wait for the last results, then a quiet tail
        s_valid <= 1'b0;
        do @(posedge clk); while (owed_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
